[sv/hall_pulse_speed_meter_top_assert.svh]
// Assertion macros for the Hall pulse speed meter checker.
`ifndef HALL_PULSE_SPEED_METER_TOP_ASSERT_SVH
`define HALL_PULSE_SPEED_METER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HPSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HPSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/hpsm_pkg.sv]
// Package with the shared types and constants of the Hall pulse speed meter.
package hpsm_pkg;

	// Width of timestamps, periods, counts and the speed quotient.
	localparam int WORD_W = 32;
	// Bits needed to count the divider iterations.
	localparam int STEP_W = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [STEP_W-1:0] step_t;

	// Wheel numerator: 1.596 m * 3600000 / 3 magnets * 256.
	localparam word_t SPEED_CONSTANT_RESET = 32'd490291200;

	// Request from the sequencer to the divider.
	typedef struct packed {
		logic start;
	} div_req_t;

	// Status from the divider back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/hpsm_div.sv]
// Restoring radix-2 divider that produces one quotient bit per cycle.
module hpsm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hpsm_pkg::div_req_t req,
	input  hpsm_pkg::word_t   dividend,
	input  hpsm_pkg::word_t   divisor,
	output hpsm_pkg::div_stat_t stat,
	output hpsm_pkg::word_t   quotient
);
	import hpsm_pkg::*;

	logic            busy_q;
	logic            done_q;
	step_t           step_q;
	word_t           rem_q;
	word_t           quo_q;
	word_t           den_q;
	logic [WORD_W:0] rem_shift;
	logic [WORD_W:0] diff;
	logic            q_bit;

	// One trial subtraction of the shifted partial remainder.
	always_comb begin
		rem_shift = {rem_q, quo_q[WORD_W-1]};
		diff      = rem_shift - {1'b0, den_q};
		q_bit     = ~diff[WORD_W];
	end

	// Iteration registers; the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				den_q  <= divisor;
			end else if (busy_q) begin
				rem_q  <= q_bit ? diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
				quo_q  <= {quo_q[WORD_W-2:0], q_bit};
				step_q <= step_q + step_t'(1);
				if (step_q == step_t'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[sv/hall_pulse_speed_meter_top.sv]
// An odd edge is absorbed in idle; an even edge goes through the divide and finish states to the output
// register, or straight to finish when the period is zero and the divider is skipped.
// in_stall stays low after an odd edge; after an even edge it holds through the one-bit-per-cycle serial
// divider, if not skipped, until the finish state loads the output register while no result is stalled.
// A finished result waits in the output register while the next edge is accepted.
// Reset (arst_n low, asynchronous) clears the edge count and start time and loads the wheel constant.
module hall_pulse_speed_meter_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            speed_constant_we,
	input  hpsm_pkg::word_t speed_constant_wdata,
	input  logic            in_valid,
	output logic            in_stall,
	input  hpsm_pkg::word_t edge_time_us,
	output logic            out_valid,
	input  logic            out_stall,
	output hpsm_pkg::word_t period_us,
	output hpsm_pkg::word_t speed_q8,
	output logic            zero_period,
	output hpsm_pkg::word_t edge_count
);
	import hpsm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t    state_q;
	word_t     speed_constant_q;
	word_t     edge_counter_q;
	word_t     start_time_q;
	word_t     period_q;
	word_t     speed_q;
	logic      zero_q;
	logic      out_valid_q;
	word_t     out_period_q;
	word_t     out_speed_q;
	logic      out_zero_q;
	word_t     out_count_q;

	logic      accept;
	logic      out_free;
	word_t     count_next;
	word_t     period_now;
	logic      even_edge;
	div_req_t  div_req;
	div_stat_t div_stat;
	word_t     div_quo;

	// Handshake decode and edge arithmetic for the incoming transaction.
	always_comb begin
		accept        = in_valid && (state_q == ST_IDLE);
		out_free      = !out_valid_q || !out_stall;
		count_next    = edge_counter_q + word_t'(1);
		period_now    = edge_time_us - start_time_q;
		even_edge     = !count_next[0];
		div_req.start = accept && even_edge && (period_now != '0);
	end

	hpsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (speed_constant_q),
		.divisor  (period_now),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// Sequencer, edge state, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			speed_constant_q <= SPEED_CONSTANT_RESET;
			edge_counter_q   <= '0;
			start_time_q     <= '0;
			period_q         <= '0;
			speed_q          <= '0;
			zero_q           <= 1'b0;
			out_valid_q      <= 1'b0;
			out_period_q     <= '0;
			out_speed_q      <= '0;
			out_zero_q       <= 1'b0;
			out_count_q      <= '0;
		end else begin
			if (speed_constant_we) begin
				speed_constant_q <= speed_constant_wdata;
			end
			// A taken result empties the output register unless the sequencer refills it now.
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						edge_counter_q <= count_next;
						if (!even_edge) begin
							start_time_q <= edge_time_us;
						end else begin
							period_q <= period_now;
							if (period_now == '0) begin
								zero_q  <= 1'b1;
								speed_q <= '1;
								state_q <= ST_FINISH;
							end else begin
								zero_q  <= 1'b0;
								state_q <= ST_DIVIDE;
							end
						end
					end
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						speed_q <= div_quo;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_period_q <= period_q;
						out_speed_q  <= speed_q;
						out_zero_q   <= zero_q;
						out_count_q  <= edge_counter_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign period_us   = out_period_q;
	assign speed_q8    = out_speed_q;
	assign zero_period = out_zero_q;
	assign edge_count  = out_count_q;

endmodule

[sv/hpsm_checker.sv]
// Port-level checker for the Hall pulse speed meter, bound to the top level.
`include "hall_pulse_speed_meter_top_assert.svh"

module hpsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] period_us,
	input logic [31:0] speed_q8,
	input logic        zero_period,
	input logic [31:0] edge_count
);

	// The flag must agree with the period it describes.
	`HPSM_ASSERT_NOW(a_zero_flag, out_valid, zero_period == (period_us == 32'd0), "zero flag mismatch")
	// A zero period saturates the speed.
	`HPSM_ASSERT_NOW(a_zero_sat, out_valid && zero_period, speed_q8 == 32'hFFFF_FFFF, "speed not saturated")
	// Results only come from even edges.
	`HPSM_ASSERT_NOW(a_even_count, out_valid, edge_count[0] == 1'b0, "result on odd edge")
	// A stalled transaction holds.
	`HPSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(speed_q8), "result dropped")

endmodule

bind hall_pulse_speed_meter_top hpsm_checker u_hpsm_checker (.*);
